/* design/sbda_pkg.sv */
// shared types and constants for the signed binary to decimal ascii converter
package sbda_pkg;

    localparam int VALUE_W   = 64;
    localparam int DIGITS    = 20;
    localparam int BCD_W     = DIGITS * 4;
    localparam int CHAR_W    = 7;
    localparam int BITCNT_W  = 6;
    localparam int DIGCNT_W  = 5;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new value, clear the digits
        logic convert;     // one shift-and-adjust step
        logic skip;        // drop a leading zero digit
        logic emit_sign;   // put '-' into the output register
        logic emit_digit;  // put the top digit into the output register
    } sbda_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic conv_last;   // this is the final conversion step
        logic top_zero;    // most significant digit is zero
        logic one_left;    // one digit remains
        logic negative;    // value being converted is negative
        logic out_free;    // output register can take a character
    } sbda_status_t;

endpackage

/* design/signed_binary_to_decimal_ascii_top.sv */
// top level of the signed 64-bit integer to decimal ascii converter
//
// input stream: one request per signed 64-bit two's complement integer on
// s_tdata. output stream: its decimal text, one ascii character per request on
// m_tdata[6:0], with m_tlast high on the final character. negative values start
// with '-', digits follow most significant first, no leading zeros, zero gives
// a single '0', and the most negative value prints its true magnitude.
//
// one value is processed at a time: after acceptance the magnitude is shifted
// bit by bit into a 20-digit bcd register with add-3 correction, then up to 19
// leading zero digits are dropped one per cycle before that loop is left, then
// one character leaves per cycle while the receiver takes each one. the next
// value is accepted as soon as the final character is in the output register,
// while that character still waits to be taken.
//
// a stalled receiver freezes the controller in its output states; the output
// register holds its character and m_tlast until taken.
// aresetn (synchronous, active low) returns to idle and drops m_tvalid.
module signed_binary_to_decimal_ascii_top
    import sbda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    // result request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
    output logic        m_tlast    // last character of the number
);

    sbda_cmd_t    cmd;
    sbda_status_t status;
    logic [CHAR_W-1:0] out_char;

    // state machine: idle, convert, skip zeros, sign, emit
    sbda_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // magnitude, bcd digits and the output register
    sbda_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    // character in the low bits, padded to a byte
    assign m_tdata = {1'b0, out_char};

endmodule

/* design/sbda_datapath.sv */
// datapath: magnitude, shift-and-add-3 bcd register, counters and output register
module sbda_datapath
    import sbda_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [VALUE_W-1:0]   value,
    input  sbda_cmd_t            cmd,
    output sbda_status_t         status,
    output logic                 out_valid,
    output logic [CHAR_W-1:0]    out_char,
    output logic                 out_last,
    input  logic                 out_ready
);

    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next, bcd_adj;
    logic                neg_reg, neg_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIGCNT_W-1:0] left_reg, left_next;
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [3:0]          top_digit;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        left_next    = left_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        valid_next   = valid_reg && !out_ready;

        if (cmd.load) begin
            neg_next     = value[VALUE_W-1];
            mag_next     = value[VALUE_W-1] ? (~value + 1'b1) : value;
            bcd_next     = '0;
            bit_cnt_next = '0;
            left_next    = DIGCNT_W'(DIGITS);
        end
        if (cmd.convert) begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        if (cmd.skip || cmd.emit_digit) begin
            bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
            left_next = left_reg - 1'b1;
        end
        if (cmd.emit_sign) begin
            char_next  = ASCII_MINUS;
            last_next  = 1'b0;
            valid_next = 1'b1;
        end
        if (cmd.emit_digit) begin
            char_next  = ASCII_ZERO + {3'd0, top_digit};
            last_next  = (left_reg == DIGCNT_W'(1));
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        left_reg    <= left_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign status.conv_last = &bit_cnt_reg;
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.one_left  = (left_reg == DIGCNT_W'(1));
    assign status.negative  = neg_reg;
    assign status.out_free  = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

/* design/sbda_controller.sv */
// controller: sequences load, conversion, zero skipping and character output
module sbda_controller
    import sbda_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sbda_status_t  status,
    output sbda_cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.convert = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (status.top_zero && !status.one_left) begin
                    cmd.skip = 1'b1;
                end else if (status.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.one_left) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* tb/signed_binary_to_decimal_ascii_top_tb.sv */
// testbench for the signed 64-bit integer to decimal ascii converter
module signed_binary_to_decimal_ascii_top_tb;
    import sbda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 310;
    localparam int HOLD_CYCLES  = 400;
    // even the worst case per value, every character stalled by the receiver plus
    // a sender gap, lets all 330 values fit well inside
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int MAX_REPORTS  = 10;

    // one expected character of a number's text
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // expected text of every accepted value, checked against each result request
    class decimal_text_scoreboard;
        text_char_t expected_text[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // work out the text of an accepted value and queue its characters
        function void note_value(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] rest;
            logic [3:0]         digit_buf[DIGITS];
            int                 count;
            text_char_t         ch;
            // the magnitude of the most negative value is exact as unsigned
            rest  = value[VALUE_W-1] ? (~value + 64'd1) : value;
            count = 0;
            do begin
                digit_buf[count] = 4'(rest % 64'd10);
                count++;
                rest = rest / 64'd10;
            end while (rest != 0);
            if (value[VALUE_W-1]) begin
                ch.code = ASCII_MINUS;
                ch.last = 1'b0;
                expected_text.push_back(ch);
            end
            for (int k = count - 1; k >= 0; k--) begin
                ch.code = ASCII_ZERO + 7'(digit_buf[k]);
                ch.last = (k == 0);
                expected_text.push_back(ch);
            end
        endfunction

        // compare one accepted character with the oldest expected one
        function void check_char(logic [7:0] data, logic last);
            text_char_t want;
            if (expected_text.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("error: character %h last %b with nothing expected", data, last);
                return;
            end
            want = expected_text.pop_front();
            if (data !== {1'b0, want.code} || last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("error: expected tdata %h last %b, got tdata %h last %b",
                             {1'b0, want.code}, want.last, data, last);
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // [63:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [6:0] character, [7] zero
    logic        m_tlast;

    decimal_text_scoreboard text_sb;
    // no idling on either side while set
    bit burst       = 1'b0;
    // long receiver hold-off requested by the stimulus
    int hold_cycles = 0;
    int cycle_count = 0;

    signed_binary_to_decimal_ascii_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // idle cycles before the next request on either side
    function automatic int draw_gap();
        return burst ? 0 : int'($urandom_range(0, 7));
    endfunction

    // random value with a spread of text lengths and both signs
    function automatic logic [63:0] random_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 2))
            0: return raw;
            1: return raw >> $urandom_range(0, 63);
            default: return -(raw >> $urandom_range(1, 63));
        endcase
    endfunction

    // offer one value and wait for the request to be taken; tvalid stays high
    // between back-to-back values so it never sees two assignments in one step
    task automatic send_value(input logic [63:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        // signals read right after the edge still hold their pre-edge values
        do @(posedge aclk); while (!s_tready);
        text_sb.note_value(value);
    endtask

    // hold the sender until every expected character has come back
    task automatic wait_drained();
        while (text_sb.pending() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, a long hold-off on request, checks every character
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            text_sb.check_char(m_tdata, m_tlast);
        end
    end

    // watchdog on the total run length
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [63:0] directed[$];
        text_sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, single digits, powers of ten and their neighbors, both extremes
        directed = '{
            64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd10, 64'd99, -64'd100,
            64'd123456789, -64'd5,
            64'd999999999999999999, 64'd1000000000000000000, -64'd1000000000000000000,
            64'h7FFF_FFFF_FFFF_FFFF,   // largest positive, 19 digits
            64'h8000_0000_0000_0000,   // most negative, true magnitude printed
            64'h8000_0000_0000_0001,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000
        };
        foreach (directed[i]) send_value(directed[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // receiver holds off while values keep coming, so the input stalls
            if (i == 60) hold_cycles = HOLD_CYCLES;
            // sender pauses until the output side has caught up
            if (i == 120) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            // stretch without any idling on either side
            if (i == 180) burst = 1'b1;
            if (i == 230) burst = 1'b0;
            send_value(random_value());
        end
        s_tvalid <= 1'b0;

        wait_drained();
        // catch any stray character after the final expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (text_sb.pending() != 0) text_sb.errors++;

        if (text_sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
